// ===== rtl/ps2mc_pkg.sv =====
package ps2mc_pkg;

    // cursor coordinate width; screen sizes are clamped to 1 .. 2**COORD_BITS
    localparam int COORD_BITS = 12;
    localparam int SIZE_W     = COORD_BITS + 1;
    localparam int CFG_W      = 13;
    localparam int CMP_W      = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(768);

    localparam logic [7:0] ACK_BYTE     = 8'hfa;
    localparam logic [7:0] STATUS_MASK  = 8'hc8;
    localparam logic [7:0] STATUS_MATCH = 8'h08;

    typedef enum logic [3:0] {
        PH_WAIT_ACK = 4'b0001,
        PH_STATUS   = 4'b0010,
        PH_DX       = 4'b0100,
        PH_DY       = 4'b1000
    } phase_t;

    // register value to usable screen size: zero acts as one, large values saturate
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] raw);
        logic [CMP_W-1:0] raw_w;
        logic [CMP_W-1:0] lim_w;
        raw_w = CMP_W'(raw);
        lim_w = CMP_W'(1) << COORD_BITS;
        if (raw == '0) begin
            return SIZE_W'(1);
        end else if (raw_w > lim_w) begin
            return lim_w[SIZE_W-1:0];
        end else begin
            return raw_w[SIZE_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/ps2_mouse_packet_cursor.sv =====
// ps2 mouse packet decoder with a clamped screen cursor
//
// s_ channel: one mouse byte per request (s_code_byte). the first 0xfa after
// reset arms the framer; then each packet is a status byte (bits 7,6,3 must
// read 0,0,1, else the byte is dropped), dx and dy as signed bytes.
// m_ channel: one result per complete packet with the new cursor position,
// the status byte and both deltas. x moves by +dx, y by -dy, each clamped
// to 0 .. size-1 of the configured screen.
// cfg_wr_*: register 0 is the screen width, register 1 the height, written
// with no wait; any valid write recenters the cursor on both axes.
// latency: the result of a dy byte is on m_ the cycle after it is taken.
// throughput: one byte per cycle, set by the single state/result register
// stage; every byte is folded into the framer state in its accept cycle.
// stall: while a result waits on m_ready, status and dx bytes are still
// taken; only a dy byte waits until the result register is free.
// reset (aresetn low, synchronous): framer waits for the acknowledge byte,
// size 1024 x 768, cursor at 512, 384, no result pending.
module ps2_mouse_packet_cursor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [ps2mc_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_code_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ps2mc_pkg::COORD_BITS-1:0]    m_cursor_x,
    output logic [ps2mc_pkg::COORD_BITS-1:0]    m_cursor_y,
    output logic [7:0]                          m_status_bits,
    output logic signed [7:0]                   m_delta_x,
    output logic signed [7:0]                   m_delta_y
);

    localparam int CB = ps2mc_pkg::COORD_BITS;
    localparam int SW = ps2mc_pkg::SIZE_W;
    localparam int AW = CB + 2; // signed sum width for one axis

    // framer and cursor state
    ps2mc_pkg::phase_t            phase_reg, phase_next;
    logic [7:0]                   held_status_reg, held_status_next;
    logic [7:0]                   held_dx_reg, held_dx_next;
    logic [CB-1:0]                pos_x_reg, pos_x_next;
    logic [CB-1:0]                pos_y_reg, pos_y_next;
    logic [ps2mc_pkg::CFG_W-1:0]  width_reg, width_next;
    logic [ps2mc_pkg::CFG_W-1:0]  height_reg, height_next;

    // result register
    logic                         m_valid_reg, m_valid_next;
    logic [CB-1:0]                out_x_reg, out_x_next;
    logic [CB-1:0]                out_y_reg, out_y_next;
    logic [7:0]                   out_status_reg, out_status_next;
    logic [7:0]                   out_dx_reg, out_dx_next;
    logic [7:0]                   out_dy_reg, out_dy_next;

    logic                         s_fire;
    logic                         cfg_hit;
    logic [SW-1:0]                size_x, size_y;
    logic [SW-1:0]                size_x_new, size_y_new;
    logic [CB-1:0]                max_x, max_y;
    logic signed [AW-1:0]         sum_x, sum_y;
    logic [CB-1:0]                clamp_x, clamp_y;

    // a dy byte needs the result register; every other byte can always go in
    assign s_ready = !m_valid_reg || m_ready || (phase_reg != ps2mc_pkg::PH_DY);
    assign s_fire  = s_valid && s_ready;

    // effective sizes of the current settings
    assign size_x = ps2mc_pkg::eff_size(width_reg);
    assign size_y = ps2mc_pkg::eff_size(height_reg);
    assign max_x  = CB'(size_x - SW'(1));
    assign max_y  = CB'(size_y - SW'(1));

    // move: x by +dx, y by -dy, in a signed word two bits wider than a coordinate
    assign sum_x = $signed({2'b00, pos_x_reg}) + AW'($signed(held_dx_reg));
    assign sum_y = $signed({2'b00, pos_y_reg}) - AW'($signed(s_code_byte));

    always_comb begin
        if (sum_x < 0) begin
            clamp_x = '0;
        end else if (sum_x[CB:0] > {1'b0, max_x}) begin
            clamp_x = max_x;
        end else begin
            clamp_x = sum_x[CB-1:0];
        end
        if (sum_y < 0) begin
            clamp_y = '0;
        end else if (sum_y[CB:0] > {1'b0, max_y}) begin
            clamp_y = max_y;
        end else begin
            clamp_y = sum_y[CB-1:0];
        end
    end

    // register writes; unknown indexes leave everything alone
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_hit     = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                ps2mc_pkg::REG_SCREEN_WIDTH: begin
                    width_next = cfg_wr_data;
                    cfg_hit    = 1'b1;
                end
                ps2mc_pkg::REG_SCREEN_HEIGHT: begin
                    height_next = cfg_wr_data;
                    cfg_hit     = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign size_x_new = ps2mc_pkg::eff_size(width_next);
    assign size_y_new = ps2mc_pkg::eff_size(height_next);

    // framer, cursor and result register
    always_comb begin
        phase_next       = phase_reg;
        held_status_next = held_status_reg;
        held_dx_next     = held_dx_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_status_next  = out_status_reg;
        out_dx_next      = out_dx_reg;
        out_dy_next      = out_dy_reg;

        if (s_fire) begin
            case (phase_reg)
                ps2mc_pkg::PH_WAIT_ACK: begin
                    if (s_code_byte == ps2mc_pkg::ACK_BYTE) begin
                        phase_next = ps2mc_pkg::PH_STATUS;
                    end
                end
                ps2mc_pkg::PH_STATUS: begin
                    // resync: bad status bytes are dropped here
                    if ((s_code_byte & ps2mc_pkg::STATUS_MASK) == ps2mc_pkg::STATUS_MATCH) begin
                        held_status_next = s_code_byte;
                        phase_next       = ps2mc_pkg::PH_DX;
                    end
                end
                ps2mc_pkg::PH_DX: begin
                    held_dx_next = s_code_byte;
                    phase_next   = ps2mc_pkg::PH_DY;
                end
                ps2mc_pkg::PH_DY: begin
                    pos_x_next      = clamp_x;
                    pos_y_next      = clamp_y;
                    phase_next      = ps2mc_pkg::PH_STATUS;
                    m_valid_next    = 1'b1;
                    out_x_next      = clamp_x;
                    out_y_next      = clamp_y;
                    out_status_next = held_status_reg;
                    out_dx_next     = held_dx_reg;
                    out_dy_next     = s_code_byte;
                end
                default: begin
                    phase_next = ps2mc_pkg::PH_WAIT_ACK;
                end
            endcase
        end

        // recenter on a write to either size register (the user writes only while idle; not enforced here)
        if (cfg_hit) begin
            pos_x_next = size_x_new[SW-1:1];
            pos_y_next = size_y_new[SW-1:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= ps2mc_pkg::PH_WAIT_ACK;
            held_status_reg <= '0;
            held_dx_reg     <= '0;
            width_reg       <= ps2mc_pkg::WIDTH_RESET;
            height_reg      <= ps2mc_pkg::HEIGHT_RESET;
            pos_x_reg       <= CB'(ps2mc_pkg::eff_size(ps2mc_pkg::WIDTH_RESET) >> 1);
            pos_y_reg       <= CB'(ps2mc_pkg::eff_size(ps2mc_pkg::HEIGHT_RESET) >> 1);
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            held_status_reg <= held_status_next;
            held_dx_reg     <= held_dx_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_status_reg <= out_status_next;
        out_dx_reg     <= out_dx_next;
        out_dy_reg     <= out_dy_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_cursor_x    = out_x_reg;
    assign m_cursor_y    = out_y_reg;
    assign m_status_bits = out_status_reg;
    assign m_delta_x     = $signed(out_dx_reg);
    assign m_delta_y     = $signed(out_dy_reg);

`ifndef NO_ASSERTIONS
    // a taken dy byte always produces a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && phase_reg == ps2mc_pkg::PH_DY) |=> m_valid)
        else $error("dy byte did not produce a result");

    // cursor stays on screen on both axes
    assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, pos_x_reg} < size_x) && ({1'b0, pos_y_reg} < size_y))
        else $error("cursor outside screen");

    // input only stalls behind a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && phase_reg == ps2mc_pkg::PH_DY))
        else $error("input stalled with no pending result");

    // framer leaves the wait state only on an acknowledge byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == ps2mc_pkg::PH_WAIT_ACK && !(s_fire && s_code_byte == ps2mc_pkg::ACK_BYTE))
        |=> phase_reg == ps2mc_pkg::PH_WAIT_ACK)
        else $error("framer armed without acknowledge");
`endif

endmodule

// ===== dv/ps2_mouse_packet_cursor_test.sv =====
`timescale 1ns / 100ps

module ps2_mouse_packet_cursor_test;

    // register indexes with no register behind them
    localparam logic [ps2mc_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = ps2mc_pkg::CFG_IDX_W'(2);
    localparam logic [ps2mc_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = ps2mc_pkg::CFG_IDX_W'(3);

    // cycles to let the framer go quiet before a register write or the end
    localparam int DRAIN_CYCLES   = 4;
    // cycles with no handshake at all before the run is given up
    localparam int WATCHDOG_LIMIT = 500;

    // one cursor report as it leaves on the m_ side
    typedef struct packed {
        logic [ps2mc_pkg::COORD_BITS-1:0] x;
        logic [ps2mc_pkg::COORD_BITS-1:0] y;
        logic [7:0]                       status;
        logic signed [7:0]                dx;
        logic signed [7:0]                dy;
    } cursor_report_t;

    // directed row: a mouse byte and, where it closes a packet, the report typed in
    typedef struct packed {
        logic [7:0]     code;
        logic           pinned;
        cursor_report_t want;
    } script_row_t;

    logic                             aclk         = 1'b0;
    logic                             aresetn      = 1'b0;
    logic                             cfg_wr_en    = 1'b0;
    logic [ps2mc_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [ps2mc_pkg::CFG_W-1:0]      cfg_wr_data  = '0;
    logic                             s_valid      = 1'b0;
    logic                             s_ready;
    logic [7:0]                       s_code_byte  = '0;
    logic                             m_valid;
    logic                             m_ready      = 1'b0;
    logic [ps2mc_pkg::COORD_BITS-1:0] m_cursor_x;
    logic [ps2mc_pkg::COORD_BITS-1:0] m_cursor_y;
    logic [7:0]                       m_status_bits;
    logic signed [7:0]                m_delta_x;
    logic signed [7:0]                m_delta_y;

    // reports predicted but not yet seen on m_
    cursor_report_t pending_reports[$];
    bit             failed = 1'b0;
    // last part of the run: no sender gaps and no receiver stalls
    bit             calm   = 1'b0;
    int             hold_left = 0;

    // predictor state, mirrors the framer and the cursor
    ps2mc_pkg::phase_t                framer;
    logic [7:0]                       status_hold;
    logic [7:0]                       dx_hold;
    logic [ps2mc_pkg::COORD_BITS-1:0] cur_x;
    logic [ps2mc_pkg::COORD_BITS-1:0] cur_y;
    logic [ps2mc_pkg::CFG_W-1:0]      width_reg;
    logic [ps2mc_pkg::CFG_W-1:0]      height_reg;

    // directed bytes, right after reset with the 1024 x 768 screen
    script_row_t script [0:22] = '{
        // anything ahead of the acknowledge is dropped, even a good status
        '{8'h08, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hff, 1'b0, '0},
        '{ps2mc_pkg::ACK_BYTE, 1'b0, '0},
        // largest right move, largest downward move (dy = -128)
        '{8'h08, 1'b0, '0},
        '{8'h7f, 1'b0, '0},
        '{8'h80, 1'b1, '{12'd639, 12'd512, 8'h08, 8'sh7f, 8'sh80}},
        // bad status bytes are skipped, a second acknowledge among them
        '{8'hc8, 1'b0, '0},
        '{ps2mc_pkg::ACK_BYTE, 1'b0, '0},
        '{8'h48, 1'b0, '0},
        '{8'h88, 1'b0, '0},
        // largest left move, largest upward move
        '{8'h3f, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h7f, 1'b1, '{12'd511, 12'd385, 8'h3f, 8'sh80, 8'sh7f}},
        // sign bits set in the status do not touch the deltas
        '{8'h38, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hff, 1'b1, '{12'd512, 12'd386, 8'h38, 8'sh01, 8'shff}},
        // acknowledge value as plain delta data
        '{8'h08, 1'b0, '0},
        '{ps2mc_pkg::ACK_BYTE, 1'b0, '0},
        '{ps2mc_pkg::ACK_BYTE, 1'b1, '{12'd506, 12'd392, 8'h08, 8'shfa, 8'shfa}},
        // zero move still reports
        '{8'h09, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{12'd506, 12'd392, 8'h09, 8'sh00, 8'sh00}}
    };

    ps2_mouse_packet_cursor dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_byte   (s_code_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cursor_x    (m_cursor_x),
        .m_cursor_y    (m_cursor_y),
        .m_status_bits (m_status_bits),
        .m_delta_x     (m_delta_x),
        .m_delta_y     (m_delta_y)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // screen size as the block uses it: zero acts as one, oversize saturates
    function automatic int usable_size(input logic [ps2mc_pkg::CFG_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > (1 << ps2mc_pkg::COORD_BITS)) return 1 << ps2mc_pkg::COORD_BITS;
        return int'(raw);
    endfunction

    function automatic logic [ps2mc_pkg::COORD_BITS-1:0] clamp_coord(input int pos,
                                                                     input int span);
        if (pos < 0) return '0;
        if (pos > span - 1) return ps2mc_pkg::COORD_BITS'(span - 1);
        return ps2mc_pkg::COORD_BITS'(pos);
    endfunction

    function automatic void recentre();
        cur_x = ps2mc_pkg::COORD_BITS'(usable_size(width_reg) / 2);
        cur_y = ps2mc_pkg::COORD_BITS'(usable_size(height_reg) / 2);
    endfunction

    // fold one mouse byte into the framer, returns 1 when a packet closes
    function automatic bit fold_code(input logic [7:0] code, output cursor_report_t rpt);
        rpt = '0;
        case (framer)
            ps2mc_pkg::PH_WAIT_ACK: begin
                if (code == ps2mc_pkg::ACK_BYTE) framer = ps2mc_pkg::PH_STATUS;
                return 1'b0;
            end
            ps2mc_pkg::PH_STATUS: begin
                if ((code & ps2mc_pkg::STATUS_MASK) == ps2mc_pkg::STATUS_MATCH) begin
                    status_hold = code;
                    framer      = ps2mc_pkg::PH_DX;
                end
                return 1'b0;
            end
            ps2mc_pkg::PH_DX: begin
                dx_hold = code;
                framer  = ps2mc_pkg::PH_DY;
                return 1'b0;
            end
            default: ;
        endcase
        // dy byte: x moves by +dx, y by -dy
        cur_x  = clamp_coord(int'(cur_x) + int'($signed(dx_hold)), usable_size(width_reg));
        cur_y  = clamp_coord(int'(cur_y) - int'($signed(code)), usable_size(height_reg));
        framer = ps2mc_pkg::PH_STATUS;
        rpt    = '{cur_x, cur_y, status_hold, dx_hold, code};
        return 1'b1;
    endfunction

    // offer one byte, wait for the request to be taken, queue its report
    task automatic push_code(input logic [7:0] code, input bit pinned,
                             input cursor_report_t pin);
        cursor_report_t rpt;
        bit             made;
        cfg_wr_en <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_byte <= code;
        do @(posedge aclk); while (!s_ready);
        made = fold_code(code, rpt);
        if (made) pending_reports.push_back(pinned ? pin : rpt);
    endtask

    // stop sending and let every expected report drain
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write enable is left high here and dropped by the next byte sent
    task automatic write_reg(input logic [ps2mc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ps2mc_pkg::CFG_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            ps2mc_pkg::REG_SCREEN_WIDTH: begin
                width_reg = data;
                recentre();
            end
            ps2mc_pkg::REG_SCREEN_HEIGHT: begin
                height_reg = data;
                recentre();
            end
            default: ;  // spare index: ignored, cursor stays put
        endcase
    endtask

    // movement byte, pushed hard one way when the phase drifts
    function automatic logic [7:0] pick_delta(input int drift);
        if (drift > 0 && $urandom_range(0, 7) != 0) return 8'($urandom_range(96, 127));
        if (drift < 0 && $urandom_range(0, 7) != 0) return 8'(256 - $urandom_range(96, 128));
        case ($urandom_range(0, 5))
            0: return 8'h7f;
            1: return 8'h80;
            2: return 8'($urandom_range(0, 3));
            3: return 8'(256 - $urandom_range(1, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    // one screen setting: write both sizes, then a run of packets with some junk
    task automatic run_phase(input logic [ps2mc_pkg::CFG_W-1:0] w,
                             input logic [ps2mc_pkg::CFG_W-1:0] h,
                             input int packets, input int drift_x, input int drift_y,
                             input int spare_at);
        logic [7:0] junk;
        logic [7:0] status;
        settle();
        write_reg(ps2mc_pkg::REG_SCREEN_WIDTH, w);
        write_reg(ps2mc_pkg::REG_SCREEN_HEIGHT, h);
        for (int n = 0; n < packets; n++) begin
            if (n == spare_at) begin
                // writes to unused indexes must not recentre
                settle();
                write_reg(REG_SPARE_2, ps2mc_pkg::CFG_W'($urandom));
                write_reg(REG_SPARE_3, ps2mc_pkg::CFG_W'($urandom));
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                junk = 8'($urandom);
                if ((junk & ps2mc_pkg::STATUS_MASK) == ps2mc_pkg::STATUS_MATCH) begin
                    junk = junk | ps2mc_pkg::STATUS_MASK;
                end
                if ($urandom_range(0, 3) == 0) junk = ps2mc_pkg::ACK_BYTE;
                push_code(junk, 1'b0, '0);
            end
            status = 8'($urandom);
            status = (status & ~ps2mc_pkg::STATUS_MASK) | ps2mc_pkg::STATUS_MATCH;
            push_code(status, 1'b0, '0);
            push_code(pick_delta(drift_x), 1'b0, '0);
            push_code(pick_delta(drift_y), 1'b0, '0);
        end
        // sometimes leave a packet half done across the next register write
        if (!calm && $urandom_range(0, 2) == 0) begin
            status = 8'($urandom);
            status = (status & ~ps2mc_pkg::STATUS_MASK) | ps2mc_pkg::STATUS_MATCH;
            push_code(status, 1'b0, '0);
            if ($urandom_range(0, 1) == 0) push_code(8'($urandom), 1'b0, '0);
        end
    endtask

    // receiver: random stall bursts, none in the calm part
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            hold_left <= $urandom_range(0, 2);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // report checker: every taken result against the oldest prediction
    always @(posedge aclk) begin
        cursor_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t unexpected report: x %0d y %0d status %h dx %h dy %h",
                         $time, m_cursor_x, m_cursor_y, m_status_bits, m_delta_x, m_delta_y);
                failed = 1'b1;
            end else begin
                want = pending_reports.pop_front();
                if (m_cursor_x !== want.x) begin
                    $display("%0t cursor_x expected %0d got %0d", $time, want.x, m_cursor_x);
                    failed = 1'b1;
                end
                if (m_cursor_y !== want.y) begin
                    $display("%0t cursor_y expected %0d got %0d", $time, want.y, m_cursor_y);
                    failed = 1'b1;
                end
                if (m_status_bits !== want.status) begin
                    $display("%0t status_bits expected %h got %h",
                             $time, want.status, m_status_bits);
                    failed = 1'b1;
                end
                if (m_delta_x !== want.dx) begin
                    $display("%0t delta_x expected %0d got %0d", $time, want.dx, m_delta_x);
                    failed = 1'b1;
                end
                if (m_delta_y !== want.dy) begin
                    $display("%0t delta_y expected %0d got %0d", $time, want.dy, m_delta_y);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog: too long without any request, report or register write
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) quiet = 0;
            else quiet++;
        end
        $display("%0t watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("ps2_mouse_packet_cursor regression: fail");
        $finish;
    end

    initial begin
        // predictor starts from the reset state
        width_reg   = ps2mc_pkg::WIDTH_RESET;
        height_reg  = ps2mc_pkg::HEIGHT_RESET;
        framer      = ps2mc_pkg::PH_WAIT_ACK;
        status_hold = '0;
        dx_hold     = '0;
        recentre();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) push_code(script[i].code, script[i].pinned, script[i].want);

        // zero width acts as one, one pixel high: cursor pinned at the origin
        run_phase(13'd0, 13'd1, 15, 0, 0, -1);
        // largest screen, driven into the far corner
        run_phase(13'd4096, 13'd4096, 30, 1, -1, -1);
        // oversize registers saturate, driven toward the origin
        run_phase(13'd8191, 13'd4097, 20, -1, 1, -1);
        // tiny screen, clamps on nearly every packet
        run_phase(13'd2, 13'd3, 15, 0, 0, -1);
        // small random screen with the spare index writes in the middle
        run_phase(ps2mc_pkg::CFG_W'($urandom_range(1, 64)),
                  ps2mc_pkg::CFG_W'($urandom_range(1, 64)),
                  20, 0, 0, 8);
        run_phase(ps2mc_pkg::CFG_W'($urandom_range(1, 4096)),
                  ps2mc_pkg::CFG_W'($urandom_range(1, 4096)),
                  25, int'($urandom_range(0, 2)) - 1, int'($urandom_range(0, 2)) - 1, -1);
        // back to the reset screen at full rate
        calm = 1'b1;
        run_phase(ps2mc_pkg::WIDTH_RESET, ps2mc_pkg::HEIGHT_RESET, 25, 0, 0, -1);

        settle();
        if (!failed && pending_reports.size() == 0) begin
            $display("ps2_mouse_packet_cursor regression: pass");
        end else begin
            $display("ps2_mouse_packet_cursor regression: fail");
        end
        $finish;
    end

endmodule
